// ===== hw/rtl/ymr_pkg.sv =====
`timescale 1ns / 1ps
package ymr_pkg;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;
    localparam logic [1:0] ACT_RSVD  = 2'd3;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_LA  = 8'h61;

    localparam logic [2:0] VD_NONE = 3'd0;
    localparam logic [2:0] VD_DATA = 3'd1;
    localparam logic [2:0] VD_HDR  = 3'd2;
    localparam logic [2:0] VD_EMPTY = 3'd3;
    localparam logic [2:0] VD_SEQ  = 3'd4;
    localparam logic [2:0] VD_FAIL = 3'd5;

    localparam logic [2:0] RP_NONE  = 3'd0;
    localparam logic [2:0] RP_ACK   = 3'd1;
    localparam logic [2:0] RP_NAK   = 3'd2;
    localparam logic [2:0] RP_CACA  = 3'd3;
    localparam logic [2:0] RP_C     = 3'd4;
    localparam logic [2:0] RP_ACKC  = 3'd5;
    localparam logic [2:0] RP_CACK  = 3'd6;

    localparam logic [2:0] SS_RUN  = 3'd0;
    localparam logic [2:0] SS_DONE = 3'd1;
    localparam logic [2:0] SS_SEND = 3'd2;
    localparam logic [2:0] SS_USER = 3'd3;
    localparam logic [2:0] SS_ERR  = 3'd4;

    localparam int QDEPTH = 2;

    // Classified event handed from the front to the back.
    typedef enum logic [2:0] {
        EV_NOP, EV_START, EV_TICK, EV_BYTE
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic [7:0] rx;
    } ev_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [9:0] data_offset;
        logic       packet_end;
        logic [2:0] packet_verdict;
        logic       block_is_1k;
        logic [7:0] block_number;
        logic [2:0] reply;
        logic [2:0] session_status;
        logic [3:0] error_count;
    } res_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0) c = {c[14:0], 1'b0} ^ CRC_POLY;
            else c = {c[14:0], 1'b0};
        end
        return c;
    endfunction
endpackage

// ===== hw/rtl/ymr_front.sv =====
`timescale 1ns / 1ps
module ymr_front
    import ymr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_rx_byte,
    output logic       q_valid,
    input  logic       q_ready,
    output ev_t        q_ev
);
    // Small FIFO of classified events.
    ev_t              mem_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH):0]   cnt_reg;
    ev_t  ev;
    logic push, pop;

    always_comb begin
        ev.rx = s_rx_byte;
        unique case (s_action)
            ACT_BYTE:  ev.kind = EV_BYTE;
            ACT_TICK:  ev.kind = EV_TICK;
            ACT_START: ev.kind = EV_START;
            default:   ev.kind = EV_NOP;
        endcase
    end

    assign s_ready = (cnt_reg != QDEPTH[$clog2(QDEPTH):0]);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_ev    = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= ev;
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{$clog2(QDEPTH){1'b0}}, push}
                               - {{$clog2(QDEPTH){1'b0}}, pop};
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QDEPTH[$clog2(QDEPTH):0]) else $error("queue overflow");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == QDEPTH[$clog2(QDEPTH):0] && !pop) |=> !s_ready)
        else $error("full not held");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> !q_valid) else $error("empty queue valid");
endmodule

// ===== hw/rtl/ymr_back.sv =====
`timescale 1ns / 1ps
module ymr_back
    import ymr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic       q_valid,
    output logic       q_ready,
    input  ev_t        q_ev,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       m_res
);
    typedef enum logic [2:0] {
        PH_IDLE, PH_CA, PH_NUM, PH_CMP, PH_DATA, PH_CRCH, PH_CRCL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        large_reg, large_next;
    logic [9:0]  bcnt_reg, bcnt_next;
    logic [7:0]  rnum_reg, rnum_next;
    logic        mism_reg, mism_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crch_reg, crch_next;
    logic        fz_reg, fz_next;
    logic [7:0]  exp_reg, exp_next;
    logic [3:0]  err_reg, err_next;
    logic        started_reg, started_next;
    logic [2:0]  ss_reg, ss_next;
    logic [3:0]  maxe_reg;
    logic        mv_reg;
    res_t        res_reg, r;
    logic        take;

    // The output register is refilled whenever it is empty or being taken.
    assign q_ready = !mv_reg || m_ready;
    assign take    = q_valid && q_ready;
    assign m_valid = mv_reg;
    assign m_res   = res_reg;

    always_comb begin
        logic [4:0]  cnt;
        logic [2:0]  erp;
        logic        show;
        logic [15:0] got;
        logic [9:0]  last;
        logic [2:0]  err_ss;
        logic [3:0]  err_cnt;
        cnt = {1'b0, err_reg} + {4'd0, started_reg};
        err_cnt = (cnt > 5'd15) ? 4'd15 : cnt[3:0];
        erp = (cnt > {1'b0, maxe_reg}) ? RP_CACA : RP_CACK;
        err_ss = (cnt > {1'b0, maxe_reg}) ? SS_ERR : ss_reg;
        got = {crch_reg, q_ev.rx};
        last = large_reg ? 10'd1023 : 10'd127;
        show = 1'b0;
        phase_next = phase_reg; large_next = large_reg; bcnt_next = bcnt_reg;
        rnum_next = rnum_reg; mism_next = mism_reg; crc_next = crc_reg;
        crch_next = crch_reg; fz_next = fz_reg; exp_next = exp_reg;
        err_next = err_reg; started_next = started_reg; ss_next = ss_reg;
        r = '0;
        if (q_ev.kind == EV_START) begin
            phase_next = PH_IDLE; large_next = 1'b0; bcnt_next = '0; rnum_next = '0;
            mism_next = 1'b0; crc_next = '0; crch_next = '0; fz_next = 1'b0;
            exp_next = '0; err_next = '0; started_next = 1'b0; ss_next = SS_RUN;
            r.reply = RP_C;
        end else if (q_ev.kind == EV_NOP || ss_reg != SS_RUN) begin
            // Ignored event: status only.
        end else if (q_ev.kind == EV_TICK) begin
            if (phase_reg != PH_IDLE && phase_reg != PH_CA) begin
                r.packet_verdict = VD_FAIL;
                show = 1'b1;
            end
            r.packet_end = 1'b1;
            r.reply = erp; err_next = err_cnt; ss_next = err_ss; phase_next = PH_IDLE;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    r.packet_end = 1'b1;
                    if (q_ev.rx == CH_SOH || q_ev.rx == CH_STX) begin
                        r.packet_end = 1'b0;
                        large_next = (q_ev.rx == CH_STX);
                        bcnt_next = '0; rnum_next = '0; mism_next = 1'b0;
                        crc_next = '0; crch_next = '0; fz_next = 1'b0;
                        phase_next = PH_NUM;
                    end else if (q_ev.rx == CH_EOT) begin
                        err_next = '0; exp_next = '0; r.reply = RP_ACK;
                    end else if (q_ev.rx == CH_CAN) begin
                        r.packet_end = 1'b0; phase_next = PH_CA;
                    end else if (q_ev.rx == CH_UA || q_ev.rx == CH_LA) begin
                        r.reply = RP_CACA; ss_next = SS_USER;
                    end else begin
                        r.reply = erp; err_next = err_cnt; ss_next = err_ss;
                    end
                end
                PH_CA: begin
                    r.packet_end = 1'b1;
                    phase_next = PH_IDLE;
                    if (q_ev.rx == CH_CAN) begin
                        err_next = '0; r.reply = RP_ACK; ss_next = SS_SEND;
                    end else begin
                        r.reply = erp; err_next = err_cnt; ss_next = err_ss;
                    end
                end
                PH_NUM: begin
                    rnum_next = q_ev.rx; phase_next = PH_CMP;
                end
                PH_CMP: begin
                    mism_next = (~q_ev.rx != rnum_reg); phase_next = PH_DATA;
                end
                PH_DATA: begin
                    r.data_valid = 1'b1; r.data_byte = q_ev.rx; r.data_offset = bcnt_reg;
                    show = 1'b1;
                    if (bcnt_reg == '0) fz_next = (q_ev.rx == 8'h00);
                    crc_next = crc_byte(crc_reg, q_ev.rx);
                    if (bcnt_reg >= last) phase_next = PH_CRCH;
                    else bcnt_next = bcnt_reg + 10'd1;
                end
                PH_CRCH: begin
                    crch_next = q_ev.rx; phase_next = PH_CRCL;
                end
                PH_CRCL: begin
                    r.packet_end = 1'b1; show = 1'b1; phase_next = PH_IDLE;
                    if (mism_reg || got != crc_reg) begin
                        r.packet_verdict = VD_FAIL;
                        r.reply = erp; err_next = err_cnt; ss_next = err_ss;
                    end else begin
                        err_next = '0;
                        if (rnum_reg != exp_reg) begin
                            r.packet_verdict = VD_SEQ; r.reply = RP_NAK;
                        end else if (exp_reg == '0 && fz_reg) begin
                            r.packet_verdict = VD_EMPTY; r.reply = RP_ACK; ss_next = SS_DONE;
                        end else begin
                            r.packet_verdict = (exp_reg == '0) ? VD_HDR : VD_DATA;
                            r.reply = (exp_reg == '0) ? RP_ACKC : RP_ACK;
                            exp_next = exp_reg + 8'd1;
                            started_next = 1'b1;
                        end
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
        if (show) begin
            r.block_is_1k = large_reg;
            r.block_number = rnum_reg;
        end
        r.session_status = ss_next;
        r.error_count = err_next;
    end

    always_ff @(posedge aclk) begin
        if (take) res_reg <= r;
        if (!aresetn) begin
            phase_reg <= PH_IDLE; large_reg <= 1'b0; bcnt_reg <= '0; rnum_reg <= '0;
            mism_reg <= 1'b0; crc_reg <= '0; crch_reg <= '0; fz_reg <= 1'b0;
            exp_reg <= '0; err_reg <= '0; started_reg <= 1'b0; ss_reg <= SS_RUN;
            maxe_reg <= 4'd5; mv_reg <= 1'b0;
        end else begin
            if (cfg_we) maxe_reg <= cfg_wdata;
            if (take) begin
                phase_reg <= phase_next; large_reg <= large_next; bcnt_reg <= bcnt_next;
                rnum_reg <= rnum_next; mism_reg <= mism_next; crc_reg <= crc_next;
                crch_reg <= crch_next; fz_reg <= fz_next; exp_reg <= exp_next;
                err_reg <= err_next; started_reg <= started_next; ss_reg <= ss_next;
            end
            if (take) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |=> (mv_reg && $stable(res_reg)))
        else $error("result lost under stall");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA && !large_reg) |-> bcnt_reg <= 10'd127)
        else $error("short block overrun");
    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && ss_reg != SS_RUN && q_ev.kind != EV_START) |=> $stable(phase_reg))
        else $error("finished session moved");
endmodule

// ===== hw/rtl/ymodem_packet_receiver.sv =====
`timescale 1ns / 1ps
// Path: a request accepted by the front is queued there, then taken by the back, which handles
// it and writes its result into the output register; the back takes none while a result is stalled.
// Throughput: one request per cycle sustained while m_ready is held; each byte is classified and
// queued in the front, then handled by the back, whose CRC update is a combinational XOR net.
// Reset: aresetn is synchronous and active low; it idles the receiver, clears all session
// state and the queue, and sets the error limit register to 5.
module ymodem_packet_receiver
    import ymr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_data_valid,
    output logic [7:0] m_data_byte,
    output logic [9:0] m_data_offset,
    output logic       m_packet_end,
    output logic [2:0] m_packet_verdict,
    output logic       m_block_is_1k,
    output logic [7:0] m_block_number,
    output logic [2:0] m_reply,
    output logic [2:0] m_session_status,
    output logic [3:0] m_error_count
);
    // The front queues classified requests so the deframer can stall on the
    // output side without at once blocking the byte stream; it holds two events.
    logic q_valid, q_ready;
    ev_t  q_ev;
    res_t res;

    ymr_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action, .s_rx_byte,
        .q_valid, .q_ready, .q_ev
    );

    // The back holds the protocol state, the CRC and the output register.
    ymr_back u_back (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .q_valid, .q_ready, .q_ev,
        .m_valid, .m_ready, .m_res(res)
    );

    assign m_data_valid     = res.data_valid;
    assign m_data_byte      = res.data_byte;
    assign m_data_offset    = res.data_offset;
    assign m_packet_end     = res.packet_end;
    assign m_packet_verdict = res.packet_verdict;
    assign m_block_is_1k    = res.block_is_1k;
    assign m_block_number   = res.block_number;
    assign m_reply          = res.reply;
    assign m_session_status = res.session_status;
    assign m_error_count    = res.error_count;
endmodule
